// ----- sv/hmc_pkg.sv -----
`default_nettype none
package hmc_pkg;

  localparam int unsigned TICKS_PER_SECOND = 1000;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned NUM_WORDS = 5;
  localparam int unsigned WRAP_LIMIT = 60;

  localparam logic [31:0] HOUR_LIMIT_RST = 32'd99999;
  localparam logic [31:0] CYCLE_LIMIT_RST = 32'd99999999;
  localparam logic [7:0] SAVE_STEP_RST = 8'd10;

  localparam int unsigned W_HOUR_HI = 0;
  localparam int unsigned W_HOUR_LO = 1;
  localparam int unsigned W_MIN_SEC = 2;
  localparam int unsigned W_CYC_HI = 3;
  localparam int unsigned W_CYC_LO = 4;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_POLL    = 2'd1,
    MODE_POWER   = 2'd2,
    MODE_RESTORE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_LOW      = 2'd1,
    STATUS_HOURS    = 2'd2,
    STATUS_CYCLES   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_HOUR_LIMIT  = 2'd0,
    REG_CYCLE_LIMIT = 2'd1,
    REG_SAVE_STEP   = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] hour_limit;
    logic [31:0] cycle_limit;
    logic [7:0]  save_step;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic        run_level;
    logic        reset_level;
    logic        cycle_level;
    logic        power_low;
    logic [31:0] load_hours;
    logic [7:0]  load_minutes;
    logic [7:0]  load_seconds;
    logic [31:0] load_cycles;
  } in_item_t;

  typedef struct packed {
    logic [31:0]          hours;
    logic [7:0]           minutes;
    logic [7:0]           seconds;
    logic [31:0]          cycles;
    status_t              status;
    logic [NUM_WORDS-1:0] write_mask;
    logic                 low_energy;
  } out_item_t;

endpackage
`default_nettype wire

// ----- sv/hmc_if.sv -----
`default_nettype none
interface hmc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        run_level;
  logic        reset_level;
  logic        cycle_level;
  logic        power_low;
  logic [31:0] load_hours;
  logic [7:0]  load_minutes;
  logic [7:0]  load_seconds;
  logic [31:0] load_cycles;

  modport source (
    output valid, mode, run_level, reset_level, cycle_level, power_low,
           load_hours, load_minutes, load_seconds, load_cycles,
    input  ready
  );
  modport sink (
    input  valid, mode, run_level, reset_level, cycle_level, power_low,
           load_hours, load_minutes, load_seconds, load_cycles,
    output ready
  );
endinterface

interface hmc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hours;
  logic [7:0]  minutes;
  logic [7:0]  seconds;
  logic [31:0] cycles;
  logic [1:0]  status;
  logic [4:0]  write_mask;
  logic        low_energy;

  modport source (
    output valid, hours, minutes, seconds, cycles, status, write_mask, low_energy,
    input  ready
  );
  modport sink (
    input  valid, hours, minutes, seconds, cycles, status, write_mask, low_energy,
    output ready
  );
endinterface
`default_nettype wire

// ----- sv/hmc_cfg.sv -----
`default_nettype none
module hmc_cfg
  import hmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output cfg_t             cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hour_limit <= HOUR_LIMIT_RST;
      cfg_r.cycle_limit <= CYCLE_LIMIT_RST;
      cfg_r.save_step <= SAVE_STEP_RST;
    end else if (wr_en) begin
      case (idx)
        REG_HOUR_LIMIT:  cfg_r.hour_limit <= cfg_pwdata;
        REG_CYCLE_LIMIT: cfg_r.cycle_limit <= cfg_pwdata;
        REG_SAVE_STEP:   cfg_r.save_step <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HOUR_LIMIT:  cfg_prdata = cfg_r.hour_limit;
      REG_CYCLE_LIMIT: cfg_prdata = cfg_r.cycle_limit;
      REG_SAVE_STEP:   cfg_prdata = {24'd0, cfg_r.save_step};
      default:         cfg_prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/hmc_core.sv -----
`default_nettype none
module hmc_core
  import hmc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     res
);

  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [7:0]        sec_r, sec_nxt;
  logic [7:0]        min_r, min_nxt;
  logic [31:0]       hour_r, hour_nxt;
  logic [31:0]       cyc_r, cyc_nxt;
  logic              rst_seen_r, rst_seen_nxt;
  logic              cyc_seen_r, cyc_seen_nxt;
  logic              low_r, low_nxt;
  logic [15:0]       saved_r [NUM_WORDS];
  logic [15:0]       saved_nxt [NUM_WORDS];
  logic [NUM_WORDS-1:0] mask;

  logic [TICK_W-1:0] tick_inc;
  logic [7:0]        sec_inc, min_inc;
  logic [31:0]       cyc_base;
  logic [15:0]       words [NUM_WORDS];
  logic [7:0]        sec_diff;
  logic [NUM_WORDS-1:0] save;
  status_t           status;

  assign tick_inc = tick_r + TICK_W'(1);
  assign sec_inc = sec_r + 8'd1;
  assign min_inc = min_r + 8'd1;

  assign words[W_HOUR_HI] = hour_r[31:16];
  assign words[W_HOUR_LO] = hour_r[15:0];
  assign words[W_MIN_SEC] = {min_r, sec_r};
  assign words[W_CYC_HI] = cyc_r[31:16];
  assign words[W_CYC_LO] = cyc_r[15:0];
  assign sec_diff = sec_r - saved_r[W_MIN_SEC][7:0];

  always_comb begin
    save = '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      save[i] = saved_r[i] != words[i];
    end
    save[W_MIN_SEC] = (saved_r[W_MIN_SEC][15:8] != min_r) || (sec_diff >= cfg.save_step);
  end

  always_comb begin
    tick_nxt = tick_r;
    sec_nxt = sec_r;
    min_nxt = min_r;
    hour_nxt = hour_r;
    cyc_nxt = cyc_r;
    rst_seen_nxt = rst_seen_r;
    cyc_seen_nxt = cyc_seen_r;
    low_nxt = low_r;
    saved_nxt = saved_r;
    mask = '0;
    cyc_base = cyc_r;
    case (item.mode)
      MODE_TICK: begin
        if (item.run_level) begin
          if (32'(tick_inc) < TICKS_PER_SECOND) begin
            tick_nxt = tick_inc;
          end else begin
            tick_nxt = '0;
            if (32'(sec_inc) < WRAP_LIMIT) begin
              sec_nxt = sec_inc;
            end else begin
              sec_nxt = '0;
              if (32'(min_inc) < WRAP_LIMIT) begin
                min_nxt = min_inc;
              end else begin
                min_nxt = '0;
                hour_nxt = hour_r + 32'd1;
              end
            end
          end
        end
      end
      MODE_POLL: begin
        if (item.reset_level && !rst_seen_r) begin
          rst_seen_nxt = 1'b1;
          hour_nxt = '0;
          min_nxt = '0;
          sec_nxt = '0;
          tick_nxt = '0;
          cyc_base = '0;
        end else if (!item.reset_level) begin
          rst_seen_nxt = 1'b0;
        end
        cyc_nxt = cyc_base;
        if (item.cycle_level && !cyc_seen_r) begin
          cyc_seen_nxt = 1'b1;
          cyc_nxt = cyc_base + 32'd1;
        end else if (!item.cycle_level) begin
          cyc_seen_nxt = 1'b0;
        end
      end
      MODE_POWER: begin
        if (low_r) begin
          low_nxt = 1'b0;
        end else begin
          low_nxt = 1'b1;
          mask = save;
          for (int i = 0; i < NUM_WORDS; i++) begin
            if (save[i]) begin
              saved_nxt[i] = words[i];
            end
          end
        end
      end
      default: begin
        low_nxt = item.power_low;
        saved_nxt[W_HOUR_HI] = item.load_hours[31:16];
        saved_nxt[W_HOUR_LO] = item.load_hours[15:0];
        saved_nxt[W_MIN_SEC] = {item.load_minutes, item.load_seconds};
        saved_nxt[W_CYC_HI] = item.load_cycles[31:16];
        saved_nxt[W_CYC_LO] = item.load_cycles[15:0];
        hour_nxt = item.load_hours;
        min_nxt = item.load_minutes;
        sec_nxt = item.load_seconds;
        cyc_nxt = item.load_cycles;
        tick_nxt = '0;
        rst_seen_nxt = 1'b0;
        cyc_seen_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (low_nxt) begin
      status = STATUS_LOW;
    end else if (hour_nxt > cfg.hour_limit) begin
      status = STATUS_HOURS;
    end else if (cyc_nxt > cfg.cycle_limit) begin
      status = STATUS_CYCLES;
    end else begin
      status = STATUS_OK;
    end
    res.hours = hour_nxt;
    res.minutes = min_nxt;
    res.seconds = sec_nxt;
    res.cycles = cyc_nxt;
    res.status = status;
    res.write_mask = mask;
    res.low_energy = low_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      sec_r <= '0;
      min_r <= '0;
      hour_r <= '0;
      cyc_r <= '0;
      rst_seen_r <= 1'b0;
      cyc_seen_r <= 1'b0;
      low_r <= 1'b0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        saved_r[i] <= '0;
      end
    end else if (fire) begin
      tick_r <= tick_nxt;
      sec_r <= sec_nxt;
      min_r <= min_nxt;
      hour_r <= hour_nxt;
      cyc_r <= cyc_nxt;
      rst_seen_r <= rst_seen_nxt;
      cyc_seen_r <= cyc_seen_nxt;
      low_r <= low_nxt;
      saved_r <= saved_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/hour_meter_with_cycle_count.sv -----
// Hour meter with cycle count. Items arrive on in_chan and each one gives exactly one result on
// out_chan. The block takes one item per clock cycle while in_chan.ready is high; an item is
// captured in an input register, the counter update runs on it once the result register is
// free and lands in the result register, from which out_chan presents it. in_chan.ready drops
// only while both registers are full and the result is not taken. Configuration registers sit
// at byte addresses 0 (hour limit), 4 (cycle limit) and 8 (seconds save step), written through
// the APB-style cfg_ port with no wait states.
`default_nettype none
module hour_meter_with_cycle_count
  import hmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  hmc_in_if.sink           in_chan,
  hmc_out_if.source        out_chan,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t      cfg;
  in_item_t  item_r;
  logic      item_v_r;
  out_item_t res;
  out_item_t out_r;
  logic      out_v_r;
  logic      out_free;
  logic      fire;

  assign out_free = !out_v_r || out_chan.ready;
  assign fire = item_v_r && out_free;
  assign in_chan.ready = !item_v_r || out_free;

  hmc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  hmc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      item_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      item_r.mode <= mode_t'(in_chan.mode);
      item_r.run_level <= in_chan.run_level;
      item_r.reset_level <= in_chan.reset_level;
      item_r.cycle_level <= in_chan.cycle_level;
      item_r.power_low <= in_chan.power_low;
      item_r.load_hours <= in_chan.load_hours;
      item_r.load_minutes <= in_chan.load_minutes;
      item_r.load_seconds <= in_chan.load_seconds;
      item_r.load_cycles <= in_chan.load_cycles;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= item_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_chan.valid = out_v_r;
  assign out_chan.hours = out_r.hours;
  assign out_chan.minutes = out_r.minutes;
  assign out_chan.seconds = out_r.seconds;
  assign out_chan.cycles = out_r.cycles;
  assign out_chan.status = out_r.status;
  assign out_chan.write_mask = out_r.write_mask;
  assign out_chan.low_energy = out_r.low_energy;

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hmc_pkg::*;

  localparam int CYCLE_BUDGET = 500000;
  localparam int RANDOM_ITEMS = 800;
  localparam int PHASES = 4;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } script_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  hmc_in_if  in_bus();
  hmc_out_if out_bus();

  hour_meter_with_cycle_count uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_bus),
    .out_chan    (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // meter state as the block should hold it
  logic [15:0] tick_cnt;
  logic [7:0]  sec_cnt;
  logic [7:0]  min_cnt;
  logic [31:0] hour_cnt;
  logic [31:0] cyc_cnt;
  logic        rst_held;
  logic        cyc_held;
  logic        low_flag;
  logic [15:0] snap [NUM_WORDS];
  logic [31:0] lim_hours;
  logic [31:0] lim_cycles;
  logic [7:0]  sec_step;

  out_item_t   owed_readings[$];
  script_row_t script[$];
  int          errors = 0;
  int          clk_cycles = 0;
  bit          calm = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    clk_cycles <= clk_cycles + 1;
    if (clk_cycles > CYCLE_BUDGET) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic out_item_t meter_next(in_item_t it);
    out_item_t   r;
    logic [15:0] w [NUM_WORDS];
    logic [7:0]  gain;
    logic        keep;
    r = '0;
    case (it.mode)
      MODE_TICK: begin
        if (it.run_level) begin
          tick_cnt = tick_cnt + 16'd1;
          if (32'(tick_cnt) >= TICKS_PER_SECOND) begin
            tick_cnt = '0;
            sec_cnt = sec_cnt + 8'd1;
            if (32'(sec_cnt) >= WRAP_LIMIT) begin
              sec_cnt = '0;
              min_cnt = min_cnt + 8'd1;
              if (32'(min_cnt) >= WRAP_LIMIT) begin
                min_cnt = '0;
                hour_cnt = hour_cnt + 32'd1;
              end
            end
          end
        end
      end
      MODE_POLL: begin
        if (it.reset_level && !rst_held) begin
          rst_held = 1'b1;
          hour_cnt = '0;
          min_cnt = '0;
          sec_cnt = '0;
          tick_cnt = '0;
          cyc_cnt = '0;
        end else if (!it.reset_level) begin
          rst_held = 1'b0;
        end
        if (it.cycle_level && !cyc_held) begin
          cyc_held = 1'b1;
          cyc_cnt = cyc_cnt + 32'd1;
        end else if (!it.cycle_level) begin
          cyc_held = 1'b0;
        end
      end
      MODE_POWER: begin
        if (low_flag) begin
          low_flag = 1'b0;
        end else begin
          low_flag = 1'b1;
          w[W_HOUR_HI] = hour_cnt[31:16];
          w[W_HOUR_LO] = hour_cnt[15:0];
          w[W_MIN_SEC] = {min_cnt, sec_cnt};
          w[W_CYC_HI] = cyc_cnt[31:16];
          w[W_CYC_LO] = cyc_cnt[15:0];
          for (int i = 0; i < NUM_WORDS; i++) begin
            if (i == W_MIN_SEC) begin
              // seconds advance is taken modulo 256
              gain = w[i][7:0] - snap[i][7:0];
              keep = (w[i][15:8] != snap[i][15:8]) || (gain >= sec_step);
            end else begin
              keep = (w[i] != snap[i]);
            end
            if (keep) begin
              snap[i] = w[i];
              r.write_mask[i] = 1'b1;
            end
          end
        end
      end
      default: begin
        low_flag = it.power_low;
        snap[W_HOUR_HI] = it.load_hours[31:16];
        snap[W_HOUR_LO] = it.load_hours[15:0];
        snap[W_MIN_SEC] = {it.load_minutes, it.load_seconds};
        snap[W_CYC_HI] = it.load_cycles[31:16];
        snap[W_CYC_LO] = it.load_cycles[15:0];
        hour_cnt = it.load_hours;
        min_cnt = it.load_minutes;
        sec_cnt = it.load_seconds;
        cyc_cnt = it.load_cycles;
        tick_cnt = '0;
        rst_held = 1'b0;
        cyc_held = 1'b0;
      end
    endcase
    if (low_flag) begin
      r.status = STATUS_LOW;
    end else if (hour_cnt > lim_hours) begin
      r.status = STATUS_HOURS;
    end else if (cyc_cnt > lim_cycles) begin
      r.status = STATUS_CYCLES;
    end else begin
      r.status = STATUS_OK;
    end
    r.hours = hour_cnt;
    r.minutes = min_cnt;
    r.seconds = sec_cnt;
    r.cycles = cyc_cnt;
    r.low_energy = low_flag;
    return r;
  endfunction

  function automatic in_item_t make_item(mode_t m, logic run, logic rst, logic cyc, logic plow,
                                         logic [31:0] h, logic [7:0] mn, logic [7:0] s,
                                         logic [31:0] c);
    in_item_t it;
    it.mode = m;
    it.run_level = run;
    it.reset_level = rst;
    it.cycle_level = cyc;
    it.power_low = plow;
    it.load_hours = h;
    it.load_minutes = mn;
    it.load_seconds = s;
    it.load_cycles = c;
    return it;
  endfunction

  function automatic out_item_t reading(logic [31:0] h, logic [7:0] mn, logic [7:0] s,
                                        logic [31:0] c, status_t st, logic [4:0] mask,
                                        logic low);
    out_item_t r;
    r.hours = h;
    r.minutes = mn;
    r.seconds = s;
    r.cycles = c;
    r.status = st;
    r.write_mask = mask;
    r.low_energy = low;
    return r;
  endfunction

  task automatic add_row(in_item_t stim, bit typed, out_item_t want);
    script_row_t row;
    row.stim = stim;
    row.typed = typed;
    row.want = want;
    script.push_back(row);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return 32'h0;
      2: return 32'h0000_FFFF;
      3: return 32'($urandom_range(0, 200000));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0: return 8'd59;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 59));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       roll;
    roll = $urandom_range(0, 99);
    it.run_level = ($urandom_range(0, 4) != 0);
    it.reset_level = ($urandom_range(0, 6) == 0);
    it.cycle_level = 1'($urandom_range(0, 1));
    it.power_low = ($urandom_range(0, 2) == 0);
    it.load_hours = pick_word();
    it.load_minutes = pick_byte();
    it.load_seconds = pick_byte();
    it.load_cycles = pick_word();
    if (roll < 35) begin
      it.mode = MODE_TICK;
    end else if (roll < 70) begin
      it.mode = MODE_POLL;
    end else if (roll < 85) begin
      it.mode = MODE_POWER;
    end else begin
      it.mode = MODE_RESTORE;
    end
    return it;
  endfunction

  function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int        gap;
    out_item_t guess;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.mode <= it.mode;
    in_bus.run_level <= it.run_level;
    in_bus.reset_level <= it.reset_level;
    in_bus.cycle_level <= it.cycle_level;
    in_bus.power_low <= it.power_low;
    in_bus.load_hours <= it.load_hours;
    in_bus.load_minutes <= it.load_minutes;
    in_bus.load_seconds <= it.load_seconds;
    in_bus.load_cycles <= it.load_cycles;
    in_bus.valid <= 1'b1;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    guess = meter_next(it);
    owed_readings.push_back(typed ? want : guess);
    @(negedge clk);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (owed_readings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic peek_limit(reg_idx_t idx, logic [31:0] want);
    logic [31:0] got;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== want) begin
      $display("%0t: register %s read expected %0h, got %0h", $time, idx.name(), want, got);
      errors++;
    end
    @(negedge clk);
  endtask

  task automatic set_limit(reg_idx_t idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_HOUR_LIMIT: lim_hours = val;
      REG_CYCLE_LIMIT: lim_cycles = val;
      REG_SAVE_STEP: sec_step = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    peek_limit(idx, idx == REG_SAVE_STEP ? {24'd0, val[7:0]} : val);
  endtask

  // restore close to a carry, then enough running ticks to cross a whole second
  task automatic run_carry_burst();
    in_item_t it;
    int       goal;
    int       ticks;
    int       roll;
    it = random_item();
    it.mode = MODE_RESTORE;
    it.load_seconds = ($urandom_range(0, 3) == 0) ? pick_byte() : 8'd59;
    it.load_minutes = ($urandom_range(0, 1) == 0) ? pick_byte() : 8'd59;
    send_item(it, 1'b0, '0);
    goal = int'(TICKS_PER_SECOND);
    ticks = 0;
    while (ticks < goal) begin
      it = random_item();
      roll = $urandom_range(0, 99);
      if (roll < 90) begin
        it.mode = MODE_TICK;
        it.run_level = 1'b1;
        ticks++;
      end else if (roll < 95) begin
        it.mode = MODE_TICK;
        it.run_level = 1'b0;
      end else if (roll < 97) begin
        it.mode = MODE_POWER;
      end else begin
        it.mode = MODE_POLL;
        it.reset_level = 1'b0;
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  initial begin
    int          stall;
    out_item_t   want;
    stall = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        if (owed_readings.size() == 0) begin
          $display("%0t: unexpected result transfer, hours %0h cycles %0h status %0d",
                   $time, out_bus.hours, out_bus.cycles, out_bus.status);
          errors++;
        end else begin
          want = owed_readings.pop_front();
          match_field("hours", want.hours, out_bus.hours);
          match_field("minutes", 32'(want.minutes), 32'(out_bus.minutes));
          match_field("seconds", 32'(want.seconds), 32'(out_bus.seconds));
          match_field("cycles", want.cycles, out_bus.cycles);
          match_field("status", 32'(want.status), 32'(out_bus.status));
          match_field("write_mask", 32'(want.write_mask), 32'(out_bus.write_mask));
          match_field("low_energy", 32'(want.low_energy), 32'(out_bus.low_energy));
        end
        stall = calm ? 0 : $urandom_range(0, 3);
      end
    end
  end

  initial begin
    int per_phase;
    int burst_at;
    int burst_phase;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_TICK;
    in_bus.run_level = 1'b0;
    in_bus.reset_level = 1'b0;
    in_bus.cycle_level = 1'b0;
    in_bus.power_low = 1'b0;
    in_bus.load_hours = '0;
    in_bus.load_minutes = '0;
    in_bus.load_seconds = '0;
    in_bus.load_cycles = '0;
    tick_cnt = '0;
    sec_cnt = '0;
    min_cnt = '0;
    hour_cnt = '0;
    cyc_cnt = '0;
    rst_held = 1'b0;
    cyc_held = 1'b0;
    low_flag = 1'b0;
    for (int i = 0; i < NUM_WORDS; i++) snap[i] = '0;
    lim_hours = HOUR_LIMIT_RST;
    lim_cycles = CYCLE_LIMIT_RST;
    sec_step = SAVE_STEP_RST;

    add_row(make_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 0, STATUS_OK, 0, 0));
    add_row(make_item(MODE_TICK, 1, 0, 0, 0, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 0, STATUS_OK, 0, 0));
    add_row(make_item(MODE_POLL, 0, 0, 1, 0, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 1, STATUS_OK, 0, 0));
    add_row(make_item(MODE_POLL, 0, 1, 0, 0, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 0, STATUS_OK, 0, 0));
    add_row(make_item(MODE_POLL, 0, 0, 1, 0, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 1, STATUS_OK, 0, 0));
    add_row(make_item(MODE_POLL, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 1, STATUS_OK, 0, 0));
    add_row(make_item(MODE_POLL, 0, 0, 1, 0, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 2, STATUS_OK, 0, 0));
    add_row(make_item(MODE_POLL, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 2, STATUS_OK, 0, 0));
    // reset and cycle edges together: clear first, then count
    add_row(make_item(MODE_POLL, 0, 1, 1, 0, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 1, STATUS_OK, 0, 0));
    add_row(make_item(MODE_POWER, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 1, STATUS_LOW, 5'b10000, 1));
    add_row(make_item(MODE_POWER, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 1, STATUS_OK, 0, 0));
    add_row(make_item(MODE_RESTORE, 0, 0, 0, 0, '1, '1, '1, '1), 1,
            reading('1, '1, '1, '1, STATUS_HOURS, 0, 0));
    add_row(make_item(MODE_TICK, 1, 0, 0, 0, 0, 0, 0, 0), 1,
            reading('1, '1, '1, '1, STATUS_HOURS, 0, 0));
    add_row(make_item(MODE_POWER, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            reading('1, '1, '1, '1, STATUS_LOW, 0, 1));
    add_row(make_item(MODE_RESTORE, 0, 0, 0, 1, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 0, STATUS_LOW, 0, 1));
    // power event while low only clears the flag
    add_row(make_item(MODE_POWER, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 0, STATUS_OK, 0, 0));
    add_row(make_item(MODE_RESTORE, 0, 0, 0, 0, 0, 0, 0, '1), 1,
            reading(0, 0, 0, '1, STATUS_CYCLES, 0, 0));
    add_row(make_item(MODE_POLL, 0, 0, 1, 0, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 0, STATUS_OK, 0, 0));
    add_row(make_item(MODE_RESTORE, 0, 0, 0, 0, 32'h0001_2345, 5, 30, 7), 1,
            reading(32'h0001_2345, 5, 30, 7, STATUS_OK, 0, 0));
    add_row(make_item(MODE_POLL, 0, 1, 0, 0, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 0, STATUS_OK, 0, 0));
    add_row(make_item(MODE_POWER, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(make_item(MODE_POWER, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(make_item(MODE_RESTORE, 0, 0, 0, 0, 0, 0, 20, 0), 1,
            reading(0, 0, 20, 0, STATUS_OK, 0, 0));
    add_row(make_item(MODE_POLL, 0, 1, 0, 0, 0, 0, 0, 0), 1,
            reading(0, 0, 0, 0, STATUS_OK, 0, 0));
    // seconds went down, wrapped advance is large
    add_row(make_item(MODE_POWER, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    peek_limit(REG_HOUR_LIMIT, HOUR_LIMIT_RST);
    peek_limit(REG_CYCLE_LIMIT, CYCLE_LIMIT_RST);
    peek_limit(REG_SAVE_STEP, {24'd0, SAVE_STEP_RST});

    foreach (script[k]) send_item(script[k].stim, script[k].typed, script[k].want);

    per_phase = RANDOM_ITEMS / PHASES;
    burst_phase = $urandom_range(0, PHASES - 1);
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin
          set_limit(REG_HOUR_LIMIT, 32'h0);
          set_limit(REG_CYCLE_LIMIT, 32'h0);
          set_limit(REG_SAVE_STEP, 32'd1);
        end
        1: begin
          set_limit(REG_HOUR_LIMIT, 32'hFFFF_FFFF);
          set_limit(REG_CYCLE_LIMIT, 32'hFFFF_FFFF);
          set_limit(REG_SAVE_STEP, 32'd255);
        end
        2: begin
          set_limit(REG_HOUR_LIMIT, 32'($urandom_range(0, 200000)));
          set_limit(REG_CYCLE_LIMIT, 32'($urandom_range(0, 200000)));
          set_limit(REG_SAVE_STEP, 32'($urandom_range(1, 255)));
        end
        default: begin
          set_limit(REG_HOUR_LIMIT, $urandom());
          set_limit(REG_CYCLE_LIMIT, 32'($urandom_range(0, 100)));
          set_limit(REG_SAVE_STEP, 32'($urandom_range(1, 20)));
        end
      endcase
      burst_at = $urandom_range(0, per_phase - 1);
      for (int n = 0; n < per_phase; n++) begin
        if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        if (p == burst_phase && n == burst_at) run_carry_burst();
        send_item(random_item(), 1'b0, '0);
      end
    end

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
sv/hmc_pkg.sv
sv/hmc_if.sv
sv/hmc_cfg.sv
sv/hmc_core.sv
sv/hour_meter_with_cycle_count.sv
bench/testbench.sv
